// ===== hw/rtl/ovle_pkg.sv =====
// Shared types and constants for the ordered value list engine.
package ovle_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_MODIFY  = 2'd2,
        OP_DISPLAY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_WALK,
        S_RESP
    } t_state;

endpackage

// ===== hw/rtl/ovle_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ovle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ordered_value_list_engine.sv =====
// Top level of the ordered value list engine: slot pool list with insert, delete, modify, display.
//
// The block keeps an insertion-ordered circular list of up to CAPACITY signed values in two
// RAMs (values and next-slot links) with registered read data; head, tail, count and the
// free-slot map sit in flip-flops. One item is worked on at a time. Insert writes the value
// and its link in S_EXEC; on a non-empty list S_LINK then writes the old tail's link, and
// S_RESP hands the result to the output register. Delete and modify walk the list through
// the RAM read port at one entry per cycle. Display gives one result per cycle, slowed only
// by back pressure on the master side. Operations on an empty list and an insert into a full
// list go from S_EXEC straight to S_RESP. A finished result waits in an output register, so
// the next item is accepted while it is still being taken.
module ordered_value_list_engine #(
    parameter int CAPACITY   = ovle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ovle_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] replacement
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] item
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    output logic        m_axis_tlast
);

    import ovle_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [DATA_WIDTH-1:0] r_repl, n_repl;
    logic [SW-1:0]         r_head, n_head;
    logic [SW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [CAPACITY-1:0]   r_free, n_free;
    logic [SW-1:0]         r_cur, n_cur;
    logic [SW-1:0]         r_prev, n_prev;
    logic [CW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_new, n_new;
    t_status               r_status, n_status;

    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [31:0]           r_out_item, n_out_item;
    logic                  r_out_last, n_out_last;

    logic                  val_we, link_we, rd_en;
    logic [SW-1:0]         val_waddr, link_waddr, rd_addr;
    logic [DATA_WIDTH-1:0] val_wdata, rd_value;
    logic [SW-1:0]         link_wdata, rd_link;

    logic [CAPACITY-1:0]   free_low;
    logic [SW-1:0]         free_idx;
    logic                  out_free;
    logic                  walk_fin;

    ovle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_value)
    );

    ovle_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    // Isolate the lowest free slot, then encode it.
    always_comb begin
        free_low = r_free & (~r_free + CAPACITY'(1));
        free_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (free_low[i]) begin
                free_idx = free_idx | SW'(i);
            end
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign walk_fin = (r_idx + CW'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_repl       <= n_repl;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_idx        <= n_idx;
        r_new        <= n_new;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_item   <= n_out_item;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_repl       = r_repl;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_free       = r_free;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_idx        = r_idx;
        n_new        = r_new;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_item   = r_out_item;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !m_axis_tready;

        s_axis_tready = 1'b0;
        val_we        = 1'b0;
        val_waddr     = r_cur;
        val_wdata     = r_repl;
        link_we       = 1'b0;
        link_waddr    = r_prev;
        link_wdata    = rd_link;
        rd_en         = 1'b0;
        rd_addr       = rd_link;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op    = t_opcode'(s_axis_tuser);
                    n_key   = DATA_WIDTH'(signed'(s_axis_tdata[31:0]));
                    n_repl  = DATA_WIDTH'(signed'(s_axis_tdata[63:32]));
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_INSERT) begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        val_we             = 1'b1;
                        val_waddr          = free_idx;
                        val_wdata          = r_key;
                        link_we            = 1'b1;
                        link_waddr         = free_idx;
                        link_wdata         = (r_count == '0) ? free_idx : r_head;
                        n_free[free_idx]   = 1'b0;
                        n_new              = free_idx;
                        n_count            = r_count + CW'(1);
                        n_status           = ST_OK;
                        if (r_count == '0) begin
                            n_head  = free_idx;
                            n_tail  = free_idx;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_LINK;
                        end
                    end
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_cur   = r_head;
                    n_prev  = r_tail;
                    n_idx   = '0;
                    n_state = S_WALK;
                end
            end
            S_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = r_new;
                n_tail     = r_new;
                n_state    = S_RESP;
            end
            S_WALK: begin
                if (r_op == OP_DISPLAY) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_out_item   = 32'(signed'(rd_value));
                        n_out_last   = walk_fin;
                        if (walk_fin) begin
                            n_state = S_IDLE;
                        end else begin
                            rd_en  = 1'b1;
                            n_prev = r_cur;
                            n_cur  = rd_link;
                            n_idx  = r_idx + CW'(1);
                        end
                    end
                end else if (rd_value == r_key) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    if (r_op == OP_MODIFY) begin
                        val_we = 1'b1;
                    end else begin
                        n_free[r_cur] = 1'b1;
                        n_count       = r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end else begin
                            link_we = 1'b1;
                            if (r_cur == r_head) begin
                                n_head = rd_link;
                            end
                            if (r_cur == r_tail) begin
                                n_tail = r_prev;
                            end
                        end
                    end
                end else if (walk_fin) begin
                    n_status = ST_MISSING;
                    n_state  = S_RESP;
                end else begin
                    rd_en  = 1'b1;
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    n_idx  = r_idx + CW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_item   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_item;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== bench/ordered_value_list_engine_tb.sv =====
// Self-checking testbench for the ordered value list engine: directed table, then random phases.
module ordered_value_list_engine_tb;
    import ovle_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 40;

    typedef struct packed {
        t_status     status;
        logic [31:0] item;
        logic        is_last;
    } list_result_t;

    typedef struct {
        t_opcode     op;
        logic [31:0] key;
        logic [31:0] repl;
        logic        fixed_exp;
        t_status     status;
    } dir_row_t;

    typedef enum logic [1:0] {PH_FILL, PH_MIX, PH_DRAIN} phase_t;
    typedef enum logic [1:0] {RX_STEADY, RX_TOGGLE, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;  // [31:0] key, [63:32] replacement
    logic [1:0]  s_axis_tuser;  // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [31:0] item
    logic [1:0]  m_axis_tuser;  // [1:0] status
    logic        m_axis_tlast;

    logic [31:0]  list_vals[$];
    list_result_t step_results[$];
    list_result_t pending_results[$];
    list_result_t want;

    int       errors = 0;
    int       stall_cycles = 0;
    int       burst_left = 0;
    bit       offering = 1'b0;
    bit       hold_off_req = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    int       rx_left = 0;
    rx_mode_t rx_mode = RX_STEADY;

    phase_t phase_seq [4] = '{PH_FILL, PH_MIX, PH_DRAIN, PH_MIX};

    dir_row_t dir_rows [22] = '{
        '{OP_DISPLAY, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_DELETE,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_MODIFY,  32'h0000_0000, 32'h0000_0001, 1'b1, ST_EMPTY},
        '{OP_INSERT,  32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_INSERT,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK},
        '{OP_INSERT,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_INSERT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_DISPLAY, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_DELETE,  32'h0000_0005, 32'h0000_0000, 1'b1, ST_MISSING},
        '{OP_MODIFY,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, ST_OK},
        '{OP_DELETE,  32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_DELETE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_INSERT,  32'h0000_0005, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_DELETE,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_MODIFY,  32'h0000_007B, 32'h0000_0000, 1'b1, ST_MISSING},
        '{OP_DISPLAY, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_DELETE,  32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_DELETE,  32'h0000_0005, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_DISPLAY, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_INSERT,  32'h55AA_55AA, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_MODIFY,  32'h55AA_55AA, 32'hAA55_AA55, 1'b1, ST_OK},
        '{OP_DISPLAY, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK}
    };

    ordered_value_list_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void apply_list_op(t_opcode op, logic [31:0] key, logic [31:0] repl);
        int hit;
        hit = -1;
        step_results.delete();
        foreach (list_vals[i]) begin
            if (hit < 0 && list_vals[i] == key) hit = i;
        end
        if (op == OP_INSERT) begin
            if (list_vals.size() >= LIST_CAP) begin
                step_results.push_back(list_result_t'{ST_FULL, 32'd0, 1'b1});
            end else begin
                list_vals.push_back(key);
                step_results.push_back(list_result_t'{ST_OK, 32'd0, 1'b1});
            end
        end else if (list_vals.size() == 0) begin
            step_results.push_back(list_result_t'{ST_EMPTY, 32'd0, 1'b1});
        end else if (op == OP_DISPLAY) begin
            foreach (list_vals[i]) begin
                step_results.push_back(
                    list_result_t'{ST_OK, list_vals[i], i == list_vals.size() - 1});
            end
        end else if (hit < 0) begin
            step_results.push_back(list_result_t'{ST_MISSING, 32'd0, 1'b1});
        end else begin
            if (op == OP_MODIFY) list_vals[hit] = repl;
            else list_vals.delete(hit);
            step_results.push_back(list_result_t'{ST_OK, 32'd0, 1'b1});
        end
    endfunction

    function automatic logic [31:0] pick_key(int hit_pct);
        logic [31:0] near;
        if (list_vals.size() != 0 && $urandom_range(0, 99) < hit_pct)
            return list_vals[$urandom_range(0, list_vals.size() - 1)];
        if ($urandom_range(0, 1) == 1)
            return $urandom;
        near = $urandom_range(0, 7);
        return ($urandom_range(0, 1) == 1) ? -near : near;
    endfunction

    task automatic stop_offer();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_item(t_opcode op, logic [31:0] key, logic [31:0] repl,
                             logic fixed_exp = 1'b0, t_status fixed_status = ST_OK);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {repl, key};
        s_axis_tuser  <= op;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_list_op(op, key, repl);
        if (fixed_exp) begin
            pending_results.push_back(list_result_t'{fixed_status, 32'd0, 1'b1});
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            stop_offer();
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic idle_until_drained();
        stop_offer();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_STEADY: m_axis_tready <= 1'b1;
                RX_TOGGLE: m_axis_tready <= ~m_axis_tready;
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) < 7);
                default:   m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d item %h last %b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.item ||
                    m_axis_tlast !== want.is_last) begin
                    errors++;
                    $display("%0t: mismatch: expected status %0d item %h last %b, got %0d %h %b",
                             $time, want.status, want.item, want.is_last,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("ordered_value_list_engine_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int          rand_sent;
        int          seq_idx;
        int          in_phase;
        int          extra;
        int          r;
        phase_t      ph;
        t_opcode     op;
        logic [31:0] key;
        rand_sent = 0;
        seq_idx = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        burst_left = $urandom_range(1, 10);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].repl,
                      dir_rows[i].fixed_exp, dir_rows[i].status);
            pace_sender();
        end

        while (rand_sent < RANDOM_ITEMS) begin
            ph = phase_seq[seq_idx % 4];
            seq_idx++;
            idle_until_drained();
            in_phase = 0;
            extra = 0;
            while (rand_sent < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                case (ph)
                    PH_FILL: begin
                        if (r < 80) op = OP_INSERT;
                        else if (r < 90) op = OP_DISPLAY;
                        else op = OP_MODIFY;
                    end
                    PH_DRAIN: begin
                        if (r < 75) op = OP_DELETE;
                        else if (r < 85) op = OP_DISPLAY;
                        else if (r < 95) op = OP_MODIFY;
                        else op = OP_INSERT;
                    end
                    default: begin
                        if (r < 35) op = OP_INSERT;
                        else if (r < 65) op = OP_DELETE;
                        else if (r < 85) op = OP_MODIFY;
                        else op = OP_DISPLAY;
                    end
                endcase
                key = pick_key(ph == PH_DRAIN ? 85 : 60);
                send_item(op, key, $urandom);
                rand_sent++;
                in_phase++;
                if (rand_sent == 120) hold_off_req <= 1'b1;
                if ((ph == PH_FILL && list_vals.size() == LIST_CAP) ||
                    (ph == PH_DRAIN && list_vals.size() == 0))
                    extra++;
                pace_sender();
                if (extra >= 4 || in_phase >= (ph == PH_MIX ? 30 : 100)) break;
            end
        end

        idle_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("ordered_value_list_engine_tb: PASS");
        else
            $display("ordered_value_list_engine_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ovle_pkg.sv
hw/rtl/ovle_ram.sv
hw/rtl/ordered_value_list_engine.sv
bench/ordered_value_list_engine_tb.sv
